FILE: design/ppd_pkg.sv
// shared constants, types and state encoding for the ppm preamble detector and decoder
package ppd_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int SPC            = 2;
   localparam int PREAMBLE_CHIPS = 16;
   localparam int MAX_FRAME_BITS = 112;
   localparam int LINE_DEPTH     = 512;
   localparam int LINE_AW        = $clog2(LINE_DEPTH);

   localparam int WIN_SAMPLES = (PREAMBLE_CHIPS + 2 * MAX_FRAME_BITS) * SPC + SPC - 1;
   localparam int FILL_W      = $clog2(WIN_SAMPLES + 1);

   localparam int CHIP_W  = SAMPLE_W + $clog2(SPC);
   localparam int PULSE_W = CHIP_W + 2;
   localparam int GAP_W   = CHIP_W + 4;
   localparam int MUL_W   = GAP_W + 8;
   localparam int LVL_W   = CHIP_W + 7;
   localparam int NUM_W   = CHIP_W + 16;
   localparam int DEN_W   = CHIP_W + 1;

   localparam int KOFF_W = (SPC > 1) ? $clog2(SPC) : 1;
   localparam int HOLD_W = $clog2(2 * SPC);

   localparam int SCAN_CHIPS = 15;
   localparam int CHIP_IDX_W = 4;
   localparam logic [15:0] PULSE_MASK = 16'h0285;
   localparam logic [15:0] GAP_MASK   = 16'h797A;
   localparam int NUM_PULSE = 4;
   localparam int PULSE_SHIFT = 10;

   localparam int NBITS_W     = 7;
   localparam int SHORT_FRAME = 56;
   localparam int LONG_FRAME  = (MAX_FRAME_BITS < 112) ? MAX_FRAME_BITS : 112;
   localparam int FRAME_BYTES = (MAX_FRAME_BITS + 7) / 8;
   localparam int FRAME_REG_W = FRAME_BYTES * 8;

   localparam int STAMP_W = 48;
   localparam int COUNT_W = 32;
   localparam int OUT_W   = 16;
   localparam int BIDX_W  = 4;
   localparam logic [OUT_W-1:0] CONF_MAX = 16'hFFFF;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 152;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_RATIO = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PULSE_FRAC = 1'd1;
   localparam logic [CSR_DATA_W-1:0] RATIO_RESET = 8'd32;
   localparam logic [CSR_DATA_W-1:0] FRAC_RESET  = 8'd128;

   typedef enum logic [4:0] {
      S_IDLE, S_CHECK, S_PRE_ADDR, S_PRE_DATA, S_RATIO_MUL, S_RATIO_CMP,
      S_PULSE_MUL, S_PULSE_CMP, S_ALIGN, S_DETECT, S_A_ADDR, S_A_DATA,
      S_B_ADDR, S_B_DATA, S_CONF_WAIT, S_BIT_END, S_LVL_WAIT, S_NZ_WAIT, S_EMIT
   } state_type;

endpackage

FILE: design/ppm_preamble_detect_decode.sv
// top level: sample window, preamble scan sequencer, bit slicer and byte output
//
// Input channel req_: one power sample per transaction, req_tuser flags a
// stream restart that drops all buffered samples before this one.
// Result channel rsp_: one transaction per decoded frame byte, 7 or 14 per
// detected frame, rsp_tlast on the final byte.
// Configuration: csr_we writes csr_wdata into register csr_index
// (0 preamble ratio, 1 minimum pulse fraction); write only while idle.
// Scan: a sample that forms no candidate is only checked. A scanned candidate
// reads 15 chip sums, and reads them again for each extra alignment offset.
// A detection slices each bit with two line reads and, unless both are zero, a
// confidence division on the shared divider, then two more divisions for
// level and noise. The single read port of the chip sum line and the divider
// serialise this work.
// Reset clears stream counters and the window; line contents need no clearing.
// While bytes wait on rsp_tready the block holds them and takes no sample.
module ppm_preamble_detect_decode (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ppd_pkg::REQ_DATA_W-1:0]       req_tdata,  // power
   input  logic [0:0]                           req_tuser,  // restart
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // byte_value, byte_index, start_index, frame_bits, mean_level, mean_noise,
   // min_confidence, preamble_count, zero pad
   output logic [ppd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast,  // last_byte
   input  logic                                 csr_we,
   input  logic [ppd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ppd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ppd_pkg::*;

   state_type state_ff, state_in;

   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [STAMP_W-1:0]    cnt_ff, cnt_in;
   logic [STAMP_W-1:0]    start_ff, start_in;
   logic [LINE_AW-1:0]    wp_ff, wp_in;
   logic [LINE_AW-1:0]    pos_ff, pos_in;
   logic [HOLD_W-1:0]     hold_ff, hold_in;
   logic [COUNT_W-1:0]    total_ff, total_in;
   logic [SAMPLE_W-1:0]   prev_ff [SPC-1];
   logic [SAMPLE_W-1:0]   prev_in [SPC-1];
   logic [CSR_DATA_W-1:0] ratio_ff, mpf_ff;

   logic [LINE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CHIP_IDX_W-1:0] chip_ff, chip_in;
   logic [KOFF_W-1:0]     koff_ff, koff_in;
   logic [PULSE_W-1:0]    p_ff, p_in;
   logic [GAP_W-1:0]      g_ff, g_in;
   logic [CHIP_W-1:0]     pc_ff [NUM_PULSE];
   logic [CHIP_W-1:0]     pc_in [NUM_PULSE];
   logic [1:0]            pidx_ff, pidx_in;
   logic [MUL_W-1:0]      prod_ff, prod_in;
   logic [PULSE_W-1:0]    bestp_ff, bestp_in;
   logic [KOFF_W-1:0]     bestk_ff, bestk_in;

   logic [LINE_AW-1:0]    a_ptr_ff, a_ptr_in;
   logic [CHIP_W-1:0]     a_ff, a_in;
   logic [OUT_W-1:0]      conf_ff, conf_in;
   logic [NBITS_W-1:0]    bit_ff, bit_in;
   logic [NBITS_W-1:0]    nbits_ff, nbits_in;
   logic [LVL_W-1:0]      lvl_ff, lvl_in;
   logic [LVL_W-1:0]      nz_ff, nz_in;
   logic [OUT_W-1:0]      minconf_ff, minconf_in;
   logic [FRAME_REG_W-1:0] bits_ff, bits_in;
   logic [OUT_W-1:0]      mlvl_ff, mlvl_in;
   logic [OUT_W-1:0]      mnz_ff, mnz_in;
   logic [BIDX_W-1:0]     bidx_ff, bidx_in;

   logic                  accept;
   logic                  restart;
   logic [LINE_AW-1:0]    now_ptr;
   logic [FILL_W-1:0]     fill_base;
   logic [FILL_W-1:0]     fill_next;
   logic [STAMP_W-1:0]    cur_idx;
   logic [CHIP_W-1:0]     chip_sum;

   logic                  ram_we;
   logic [LINE_AW-1:0]    ram_raddr;
   logic [CHIP_W-1:0]     ram_rdata;

   logic [CSR_DATA_W-1:0] mul_a;
   logic [GAP_W-1:0]      mul_b;
   logic [MUL_W-1:0]      mul_p;
   logic [MUL_W-1:0]      p_times40;

   logic                  div_start;
   logic [NUM_W-1:0]      div_num;
   logic [DEN_W-1:0]      div_den;
   logic                  div_done;
   logic [NUM_W-1:0]      div_quot;
   logic [OUT_W-1:0]      quot_sat;

   logic                  pre_last;
   logic                  ratio_fail;
   logic                  pulse_fail;
   logic                  a_gt_b;
   logic [CHIP_W-1:0]     hi_val, lo_val;
   logic [DEN_W-1:0]      ab_sum;
   logic [NBITS_W-1:0]    nbits_new;
   logic [NBITS_W-1:0]    bit_next;
   logic                  slice_last;
   logic [NBITS_W:0]      nbytes;
   logic                  byte_last;

   // front end
   assign accept    = req_tvalid && req_tready;
   assign restart   = req_tuser[0];
   assign now_ptr   = restart ? '0 : wp_ff;
   assign fill_base = restart ? '0 : fill_ff;
   assign fill_next = (fill_base < FILL_W'(WIN_SAMPLES)) ? fill_base + 1'b1 : fill_base;
   assign cur_idx   = restart ? '0 : cnt_ff;

   always_comb begin
      chip_sum = CHIP_W'(req_tdata);
      for (int i = 0; i < SPC - 1; i++) begin
         chip_sum = chip_sum + CHIP_W'(prev_ff[i]);
      end
   end

   assign ram_we = accept && (fill_next >= FILL_W'(SPC));

   ppd_ram #(
      .WIDTH (CHIP_W),
      .DEPTH (LINE_DEPTH)
   ) u_chip_line (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (LINE_AW'(now_ptr - LINE_AW'(SPC - 1))),
      .wr_data (chip_sum),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ppd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // shared multiplier
   assign mul_a     = (state_ff == S_RATIO_MUL) ? ratio_ff : mpf_ff;
   assign mul_b     = (state_ff == S_RATIO_MUL) ? g_ff : GAP_W'(p_ff);
   assign mul_p     = MUL_W'(mul_a) * MUL_W'(mul_b);
   assign p_times40 = (MUL_W'(p_ff) << 5) + (MUL_W'(p_ff) << 3);

   assign pre_last   = chip_ff == CHIP_IDX_W'(SCAN_CHIPS - 1);
   assign ratio_fail = (p_ff == '0) || (p_times40 < prod_ff);
   assign pulse_fail = (MUL_W'(pc_ff[pidx_ff]) << PULSE_SHIFT) < prod_ff;

   assign a_gt_b  = a_ff > ram_rdata;
   assign hi_val  = a_gt_b ? a_ff : ram_rdata;
   assign lo_val  = a_gt_b ? ram_rdata : a_ff;
   assign ab_sum  = DEN_W'(a_ff) + DEN_W'(ram_rdata);
   assign quot_sat = (|div_quot[NUM_W-1:OUT_W]) ? CONF_MAX : div_quot[OUT_W-1:0];

   assign nbits_new  = (bit_ff == NBITS_W'(4))
                       ? (bits_ff[4] ? NBITS_W'(LONG_FRAME) : NBITS_W'(SHORT_FRAME))
                       : nbits_ff;
   assign bit_next   = bit_ff + 1'b1;
   assign slice_last = bit_next == nbits_new;

   assign nbytes    = ((NBITS_W + 1)'(nbits_ff) + (NBITS_W + 1)'(7)) >> 3;
   assign byte_last = (NBITS_W + 1)'(bidx_ff) == nbytes - 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (req_tvalid) state_in = S_CHECK;
         S_CHECK: begin
            if (fill_ff < FILL_W'(WIN_SAMPLES) || hold_ff != '0) state_in = S_IDLE;
            else state_in = S_PRE_ADDR;
         end
         S_PRE_ADDR:  state_in = S_PRE_DATA;
         S_PRE_DATA: begin
            if (pre_last) state_in = (koff_ff == '0) ? S_RATIO_MUL : S_ALIGN;
            else state_in = S_PRE_ADDR;
         end
         S_RATIO_MUL: state_in = S_RATIO_CMP;
         S_RATIO_CMP: state_in = ratio_fail ? S_IDLE : S_PULSE_MUL;
         S_PULSE_MUL: state_in = S_PULSE_CMP;
         S_PULSE_CMP: begin
            if (pulse_fail) state_in = S_IDLE;
            else if (pidx_ff == 2'(NUM_PULSE - 1)) state_in = (SPC > 1) ? S_PRE_ADDR : S_DETECT;
         end
         S_ALIGN:     state_in = (koff_ff == KOFF_W'(SPC - 1)) ? S_DETECT : S_PRE_ADDR;
         S_DETECT:    state_in = S_A_ADDR;
         S_A_ADDR:    state_in = S_A_DATA;
         S_A_DATA:    state_in = S_B_ADDR;
         S_B_ADDR:    state_in = S_B_DATA;
         S_B_DATA:    state_in = (ab_sum == '0) ? S_BIT_END : S_CONF_WAIT;
         S_CONF_WAIT: if (div_done) state_in = S_BIT_END;
         S_BIT_END:   state_in = slice_last ? S_LVL_WAIT : S_A_ADDR;
         S_LVL_WAIT:  if (div_done) state_in = S_NZ_WAIT;
         S_NZ_WAIT:   if (div_done) state_in = S_EMIT;
         S_EMIT:      if (rsp_tready && byte_last) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      fill_in    = fill_ff;
      cnt_in     = cnt_ff;
      start_in   = start_ff;
      wp_in      = wp_ff;
      pos_in     = pos_ff;
      hold_in    = hold_ff;
      total_in   = total_ff;
      prev_in    = prev_ff;
      rd_ptr_in  = rd_ptr_ff;
      chip_in    = chip_ff;
      koff_in    = koff_ff;
      p_in       = p_ff;
      g_in       = g_ff;
      pc_in      = pc_ff;
      pidx_in    = pidx_ff;
      prod_in    = prod_ff;
      bestp_in   = bestp_ff;
      bestk_in   = bestk_ff;
      a_ptr_in   = a_ptr_ff;
      a_in       = a_ff;
      conf_in    = conf_ff;
      bit_in     = bit_ff;
      nbits_in   = nbits_ff;
      lvl_in     = lvl_ff;
      nz_in      = nz_ff;
      minconf_in = minconf_ff;
      bits_in    = bits_ff;
      mlvl_in    = mlvl_ff;
      mnz_in     = mnz_ff;
      bidx_in    = bidx_ff;
      ram_raddr  = rd_ptr_ff;
      div_start  = 1'b0;
      div_num    = NUM_W'({hi_val - lo_val, 16'b0});
      div_den    = ab_sum;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               fill_in  = fill_next;
               cnt_in   = cur_idx + 1'b1;
               start_in = cur_idx - STAMP_W'(WIN_SAMPLES - 1);
               wp_in    = now_ptr + 1'b1;
               pos_in   = now_ptr - LINE_AW'(WIN_SAMPLES - 1);
               if (restart) hold_in = '0;
               prev_in[0] = req_tdata;
               for (int i = 1; i < SPC - 1; i++) begin
                  prev_in[i] = prev_ff[i-1];
               end
            end
         end
         S_CHECK: begin
            if (fill_ff >= FILL_W'(WIN_SAMPLES) && hold_ff != '0) hold_in = hold_ff - 1'b1;
            rd_ptr_in = pos_ff;
            chip_in   = '0;
            koff_in   = '0;
            p_in      = '0;
            g_in      = '0;
            pidx_in   = '0;
         end
         S_PRE_DATA: begin
            if (PULSE_MASK[chip_ff]) begin
               p_in = p_ff + PULSE_W'(ram_rdata);
               if (koff_ff == '0) begin
                  pc_in[pidx_ff] = ram_rdata;
                  pidx_in = pidx_ff + 1'b1;
               end
            end
            if (GAP_MASK[chip_ff] && koff_ff == '0) g_in = g_ff + GAP_W'(ram_rdata);
            chip_in   = chip_ff + 1'b1;
            rd_ptr_in = rd_ptr_ff + LINE_AW'(SPC);
         end
         S_RATIO_MUL: prod_in = mul_p;
         S_RATIO_CMP: begin
            bestp_in = p_ff;
            bestk_in = '0;
         end
         S_PULSE_MUL: begin
            prod_in = mul_p;
            pidx_in = '0;
         end
         S_PULSE_CMP: begin
            pidx_in   = pidx_ff + 1'b1;
            koff_in   = KOFF_W'(1);
            chip_in   = '0;
            p_in      = '0;
            rd_ptr_in = pos_ff + LINE_AW'(1);
         end
         S_ALIGN: begin
            if (p_ff > bestp_ff) begin
               bestp_in = p_ff;
               bestk_in = koff_ff;
            end
            koff_in   = koff_ff + 1'b1;
            chip_in   = '0;
            p_in      = '0;
            rd_ptr_in = pos_ff + LINE_AW'(koff_ff) + LINE_AW'(1);
         end
         S_DETECT: begin
            total_in   = total_ff + 1'b1;
            hold_in    = HOLD_W'(bestk_ff) + HOLD_W'(SPC - 1);
            start_in   = start_ff + STAMP_W'(bestk_ff);
            a_ptr_in   = pos_ff + LINE_AW'(bestk_ff) + LINE_AW'(PREAMBLE_CHIPS * SPC);
            bit_in     = '0;
            nbits_in   = NBITS_W'(MAX_FRAME_BITS);
            lvl_in     = '0;
            nz_in      = '0;
            minconf_in = CONF_MAX;
         end
         S_A_ADDR: ram_raddr = a_ptr_ff;
         S_A_DATA: a_in = ram_rdata;
         S_B_ADDR: ram_raddr = a_ptr_ff + LINE_AW'(SPC);
         S_B_DATA: begin
            bits_in  = {bits_ff[FRAME_REG_W-2:0], a_gt_b};
            lvl_in   = lvl_ff + LVL_W'(hi_val);
            nz_in    = nz_ff + LVL_W'(lo_val);
            conf_in  = '0;
            a_ptr_in = a_ptr_ff + LINE_AW'(2 * SPC);
            if (ab_sum != '0) div_start = 1'b1;
         end
         S_CONF_WAIT: if (div_done) conf_in = quot_sat;
         S_BIT_END: begin
            if (conf_ff < minconf_ff) minconf_in = conf_ff;
            nbits_in = nbits_new;
            bit_in   = bit_next;
            if (slice_last) begin
               div_start = 1'b1;
               div_num   = NUM_W'(lvl_ff);
               div_den   = DEN_W'(nbits_new) * DEN_W'(SPC);
            end
         end
         S_LVL_WAIT: begin
            if (div_done) begin
               mlvl_in   = div_quot[OUT_W-1:0];
               div_start = 1'b1;
               div_num   = NUM_W'(nz_ff);
               div_den   = DEN_W'(nbits_ff) * DEN_W'(SPC);
            end
         end
         S_NZ_WAIT: begin
            if (div_done) begin
               mnz_in  = div_quot[OUT_W-1:0];
               bidx_in = '0;
               if (nbits_ff == NBITS_W'(LONG_FRAME)) bits_in = bits_ff << (FRAME_REG_W - LONG_FRAME);
               else bits_in = bits_ff << (FRAME_REG_W - SHORT_FRAME);
            end
         end
         S_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               bits_in = bits_ff << 8;
               bidx_in = bidx_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         cnt_ff   <= '0;
         wp_ff    <= '0;
         hold_ff  <= '0;
         total_ff <= '0;
         ratio_ff <= RATIO_RESET;
         mpf_ff   <= FRAC_RESET;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         cnt_ff   <= cnt_in;
         wp_ff    <= wp_in;
         hold_ff  <= hold_in;
         total_ff <= total_in;
         if (csr_we) begin
            case (csr_index)
               CSR_PREAMBLE_RATIO: ratio_ff <= csr_wdata;
               CSR_MIN_PULSE_FRAC: mpf_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
      start_ff   <= start_in;
      pos_ff     <= pos_in;
      prev_ff    <= prev_in;
      rd_ptr_ff  <= rd_ptr_in;
      chip_ff    <= chip_in;
      koff_ff    <= koff_in;
      p_ff       <= p_in;
      g_ff       <= g_in;
      pc_ff      <= pc_in;
      pidx_ff    <= pidx_in;
      prod_ff    <= prod_in;
      bestp_ff   <= bestp_in;
      bestk_ff   <= bestk_in;
      a_ptr_ff   <= a_ptr_in;
      a_ff       <= a_in;
      conf_ff    <= conf_in;
      bit_ff     <= bit_in;
      nbits_ff   <= nbits_in;
      lvl_ff     <= lvl_in;
      nz_ff      <= nz_in;
      minconf_ff <= minconf_in;
      bits_ff    <= bits_in;
      mlvl_ff    <= mlvl_in;
      mnz_ff     <= mnz_in;
      bidx_ff    <= bidx_in;
   end

   assign rsp_tlast = byte_last;
   assign rsp_tdata = {5'b0, total_ff, minconf_ff, mnz_ff, mlvl_ff, nbits_ff, start_ff,
                       bidx_ff, bits_ff[FRAME_REG_W-1 -: 8]};

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("result shown while taking samples");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_CHECK)
      else $error("accepted sample not checked");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN_SAMPLES))
      else $error("fill count beyond window");

   a_hold_bound: assert property (@(posedge clock) disable iff (reset)
      hold_ff <= HOLD_W'(2 * SPC - 2))
      else $error("scan holdoff out of range");

endmodule

FILE: design/ppd_ram.sv
// generic single write, single read ram with registered read data
module ppd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/ppd_div.sv
// restoring divider, one quotient bit per cycle
module ppd_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [ppd_pkg::NUM_W-1:0]  num,
   input  logic [ppd_pkg::DEN_W-1:0]  den,
   output logic                       done,
   output logic [ppd_pkg::NUM_W-1:0]  quot
);
   import ppd_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  q_ff, q_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    trial;
   logic              ge;

   assign trial = {rem_ff, q_ff[NUM_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         q_in   = {q_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule
